/* design/assert_macros.svh */
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on the block clock.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on the block clock.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants for the barometric pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int DIV_W = 32;
	localparam int CFG_W = 48;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_AC_SIGNED   = 3'd0;
	localparam logic [IDX_W-1:0] REG_AC_UNSIGNED = 3'd1;
	localparam logic [IDX_W-1:0] REG_B_TERMS     = 3'd2;
	localparam logic [IDX_W-1:0] REG_MC_MD       = 3'd3;
	localparam logic [IDX_W-1:0] REG_OVERSAMPLING = 3'd4;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [18:0] raw_press;
	} in_t;

	typedef struct packed {
		logic signed [15:0] temp_tenths;
		logic [17:0]        press_pa;
		logic               div_error;
	} out_t;

endpackage

/* design/bpc_udiv.sv */
// ----------------------------------------------------------------------------
// bpc_udiv
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_udiv (
	input  logic                    clk,
	input  logic                    en,
	input  logic [bpc_pkg::DIV_W-1:0] num,
	input  logic [bpc_pkg::DIV_W-1:0] den,
	output logic [bpc_pkg::DIV_W-1:0] quo
);
	import bpc_pkg::*;

	logic [DIV_W-1:0] rem_s [DIV_W];
	logic [DIV_W-1:0] num_s [DIV_W];
	logic [DIV_W-1:0] den_s [DIV_W];
	logic [DIV_W-1:0] quo_s [DIV_W];

	logic [DIV_W-1:0] rem_n [DIV_W];
	logic [DIV_W-1:0] num_n [DIV_W];
	logic [DIV_W-1:0] quo_n [DIV_W];

	always_comb begin
		logic [DIV_W:0]   r2;
		logic [DIV_W-1:0] pr, pn, pd, pq;
		for (int k = 0; k < DIV_W; k++) begin
			if (k == 0) begin
				pr = '0;
				pn = num;
				pd = den;
				pq = '0;
			end else begin
				pr = rem_s[k-1];
				pn = num_s[k-1];
				pd = den_s[k-1];
				pq = quo_s[k-1];
			end
			r2 = {pr, pn[DIV_W-1]};
			if (r2 >= {1'b0, pd}) begin
				r2 = r2 - {1'b0, pd};
				quo_n[k] = {pq[DIV_W-2:0], 1'b1};
			end else begin
				quo_n[k] = {pq[DIV_W-2:0], 1'b0};
			end
			rem_n[k] = r2[DIV_W-1:0];
			num_n[k] = {pn[DIV_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			for (int k = 0; k < DIV_W; k++) begin
				rem_s[k] <= rem_n[k];
				num_s[k] <= num_n[k];
				quo_s[k] <= quo_n[k];
			end
			for (int k = 1; k < DIV_W; k++) begin
				den_s[k] <= den_s[k-1];
			end
		end
	end

	assign quo = quo_s[DIV_W-1];

endmodule

/* design/barometric_pressure_compensation.sv */
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | signals                            | moves
//  in      | in_valid, in_ready, in_data        | raw temp / raw pressure word
//  out     | out_valid, out_ready, out_data     | compensated result word
//  cfg     | cfg_we, cfg_index, cfg_data        | calibration / oversampling
//
// One word per cycle unless the output stalls; 2 front stages, a 32-stage divider
// for B5, 7 pressure stages, a 32-stage divider for p, 3 back stages.
// The whole pipe advances together; out_data is the last stage register.
// A stalled output freezes every stage; bubbles stay in place while stalled.
// Reset clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  bpc_pkg::in_t            in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output bpc_pkg::out_t           out_data,
	input  logic                    cfg_we,
	input  logic [bpc_pkg::IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0] cfg_data
);
	import bpc_pkg::*;
	`include "assert_macros.svh"

	typedef struct packed {
		logic               v;
		logic [18:0]        up;
		logic signed [31:0] x1t;
		logic               neg;
		logic               dz;
		logic [31:0]        nmag;
		logic [31:0]        dmag;
		logic signed [31:0] b5;
		logic signed [31:0] b6;
		logic signed [31:0] sq;
		logic signed [31:0] x2p;
		logic signed [31:0] x1p3;
		logic signed [31:0] x1b;
		logic signed [31:0] x2b;
		logic signed [31:0] b3pre;
		logic signed [31:0] x3bpre;
		logic signed [31:0] b3;
		logic [31:0]        u;
		logic [31:0]        b4;
		logic [31:0]        b7;
		logic               bz;
		logic               br;
		logic [31:0]        dnum;
		logic signed [31:0] p;
		logic signed [31:0] x1q;
		logic signed [31:0] x2q;
	} pipe_t;

	localparam logic signed [31:0] C_4000  = 32'sd4000;
	localparam logic signed [31:0] C_32768 = 32'sd32768;
	localparam logic [31:0]        C_50000 = 32'd50000;
	localparam logic signed [31:0] C_3038  = 32'sd3038;
	localparam logic signed [31:0] C_M7357 = -32'sd7357;
	localparam logic signed [31:0] C_3791  = 32'sd3791;
	localparam logic signed [31:0] T_MIN   = -32'sd32768;
	localparam logic signed [31:0] T_MAX   = 32'sd32767;
	localparam logic signed [31:0] P_MAX   = 32'sd262143;

	// truncating signed divide by four
	function automatic logic signed [31:0] div4(input logic signed [31:0] v);
		logic signed [31:0] a;
		a = v + (v[31] ? 32'sd3 : 32'sd0);
		return a >>> 2;
	endfunction

	logic [47:0] cal_ac_s_q, cal_ac_u_q;
	logic [31:0] cal_b_q, cal_mcmd_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_ac_s_q <= '0;
			cal_ac_u_q <= '0;
			cal_b_q    <= '0;
			cal_mcmd_q <= '0;
			oss_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AC_SIGNED:    cal_ac_s_q <= cfg_data[47:0];
				REG_AC_UNSIGNED:  cal_ac_u_q <= cfg_data[47:0];
				REG_B_TERMS:      cal_b_q    <= cfg_data[31:0];
				REG_MC_MD:        cal_mcmd_q <= cfg_data[31:0];
				REG_OVERSAMPLING: oss_q      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0] ac4, ac5, ac6;
	assign ac1 = {{16{cal_ac_s_q[15]}}, cal_ac_s_q[15:0]};
	assign ac2 = {{16{cal_ac_s_q[31]}}, cal_ac_s_q[31:16]};
	assign ac3 = {{16{cal_ac_s_q[47]}}, cal_ac_s_q[47:32]};
	assign ac4 = cal_ac_u_q[15:0];
	assign ac5 = cal_ac_u_q[31:16];
	assign ac6 = cal_ac_u_q[47:32];
	assign b1  = {{16{cal_b_q[15]}}, cal_b_q[15:0]};
	assign b2  = {{16{cal_b_q[31]}}, cal_b_q[31:16]};
	assign mc  = {{16{cal_mcmd_q[15]}}, cal_mcmd_q[15:0]};
	assign md  = {{16{cal_mcmd_q[31]}}, cal_mcmd_q[31:16]};

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	pipe_t s1_s, s2_s, s3_s, s4_s, s5_s, s6_s, s7_s, s8_s, s9_s, s10_s, s11_s;
	pipe_t n1, n2, n3, n4, n5, n6, n7, n8, n9, n10, n11;
	pipe_t tdl_s [DIV_W];
	pipe_t pdl_s [DIV_W];
	logic        v_s12;
	out_t        out_s12, n12;
	logic [31:0] tquo, pquo;

	bpc_udiv u_tdiv (.clk(clk), .en(en), .num(s2_s.nmag), .den(s2_s.dmag), .quo(tquo));
	bpc_udiv u_pdiv (.clk(clk), .en(en), .num(s9_s.dnum), .den(s9_s.b4), .quo(pquo));

	always_comb begin
		logic signed [16:0] dt;
		logic signed [33:0] m1;
		logic signed [31:0] den, nsig, x2, x3, t6, p2, t32, sm;
		logic signed [63:0] ma, mb, mcc;
		logic [47:0]        m8;
		logic [63:0]        m9;
		logic [31:0]        qv;

		// s1: x1 of the temperature term
		n1    = '0;
		n1.v  = in_valid;
		n1.up = in_data.raw_press;
		dt    = $signed({1'b0, in_data.raw_temp}) - $signed({1'b0, ac6});
		m1    = dt * $signed({1'b0, ac5});
		n1.x1t = $signed(m1[31:0]) >>> 15;

		// s2: signed divide set up as magnitudes
		n2      = s1_s;
		den     = s1_s.x1t + md;
		nsig    = mc <<< 11;
		n2.dz   = (den == 32'sd0);
		n2.neg  = nsig[31] ^ den[31];
		n2.nmag = nsig[31] ? -nsig : nsig;
		n2.dmag = den[31] ? -den : den;

		// s3: B5, B6
		n3    = tdl_s[DIV_W-1];
		x2    = n3.neg ? -$signed(tquo) : $signed(tquo);
		n3.b5 = n3.x1t + x2;
		n3.b6 = n3.b5 - C_4000;

		// s4
		n4      = s3_s;
		ma      = s3_s.b6 * s3_s.b6;
		mb      = ac2 * s3_s.b6;
		mcc     = ac3 * s3_s.b6;
		n4.sq   = $signed(ma[31:0]) >>> 12;
		n4.x2p  = $signed(mb[31:0]) >>> 11;
		n4.x1p3 = $signed(mcc[31:0]) >>> 13;

		// s5
		n5     = s4_s;
		ma     = b2 * s4_s.sq;
		mb     = b1 * s4_s.sq;
		n5.x1b = $signed(ma[31:0]) >>> 11;
		n5.x2b = $signed(mb[31:0]) >>> 16;

		// s6
		n6        = s5_s;
		x3        = s5_s.x1b + s5_s.x2p;
		t6        = (ac1 <<< 2) + x3;
		n6.b3pre  = (t6 <<< oss_q) + 32'sd2;
		n6.x3bpre = s5_s.x1p3 + s5_s.x2b + 32'sd2;

		// s7
		n7    = s6_s;
		n7.b3 = div4(s6_s.b3pre);
		n7.u  = div4(s6_s.x3bpre) + C_32768;

		// s8: B4, B7
		n8    = s7_s;
		m8    = {16'b0, s7_s.u} * {32'b0, ac4};
		n8.b4 = m8[31:0] >> 15;
		m9    = {32'b0, {13'b0, s7_s.up} - s7_s.b3} * {32'b0, (C_50000 >> oss_q)};
		n8.b7 = m9[31:0];

		// s9: pick the division branch
		n9      = s8_s;
		n9.bz   = (s8_s.b4 == 32'd0);
		n9.br   = s8_s.b7[31];
		n9.dnum = s8_s.b7[31] ? s8_s.b7 : {s8_s.b7[30:0], 1'b0};

		// s10
		n10     = pdl_s[DIV_W-1];
		qv      = n10.br ? {pquo[30:0], 1'b0} : pquo;
		n10.p   = $signed(qv);
		ma      = (n10.p >>> 8) * (n10.p >>> 8);
		mb      = n10.p * C_M7357;
		n10.x1q = $signed(ma[31:0]);
		n10.x2q = $signed(mb[31:0]);

		// s11
		n11     = s10_s;
		ma      = s10_s.x1q * C_3038;
		n11.x1q = $signed(ma[31:0]) >>> 16;
		n11.x2q = s10_s.x2q >>> 16;

		// s12: final sum and clamps, or the divide-error word
		sm  = s11_s.x1q + s11_s.x2q + C_3791;
		p2  = s11_s.p + (sm >>> 4);
		t32 = (s11_s.b5 + 32'sd8) >>> 4;
		n12 = '0;
		if (s11_s.dz || s11_s.bz) begin
			n12.div_error = 1'b1;
		end else begin
			if (t32 < T_MIN)      n12.temp_tenths = T_MIN[15:0];
			else if (t32 > T_MAX) n12.temp_tenths = T_MAX[15:0];
			else                  n12.temp_tenths = t32[15:0];
			if (p2 < 32'sd0)      n12.press_pa = '0;
			else if (p2 > P_MAX)  n12.press_pa = P_MAX[17:0];
			else                  n12.press_pa = p2[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_s  <= '0;
			s2_s  <= '0;
			s3_s  <= '0;
			s4_s  <= '0;
			s5_s  <= '0;
			s6_s  <= '0;
			s7_s  <= '0;
			s8_s  <= '0;
			s9_s  <= '0;
			s10_s <= '0;
			s11_s <= '0;
			v_s12 <= 1'b0;
			for (int k = 0; k < DIV_W; k++) begin
				tdl_s[k] <= '0;
				pdl_s[k] <= '0;
			end
		end else if (en) begin
			s1_s  <= n1;
			s2_s  <= n2;
			s3_s  <= n3;
			s4_s  <= n4;
			s5_s  <= n5;
			s6_s  <= n6;
			s7_s  <= n7;
			s8_s  <= n8;
			s9_s  <= n9;
			s10_s <= n10;
			s11_s <= n11;
			v_s12 <= s11_s.v;
			tdl_s[0] <= s2_s;
			pdl_s[0] <= s9_s;
			for (int k = 1; k < DIV_W; k++) begin
				tdl_s[k] <= tdl_s[k-1];
				pdl_s[k] <= pdl_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s12 <= n12;
		end
	end

	assign out_valid = v_s12;
	assign out_data  = out_s12;

	`ASSERT_NOW(a_err_zero, out_valid && out_data.div_error,
		out_data.temp_tenths == 16'sd0 && out_data.press_pa == 18'd0,
		"error word carries nonzero fields")
	`ASSERT_NEXT(a_stall_hold, !en, $stable(s1_s.v) && $stable(v_s12),
		"pipeline moved during stall")
	`ASSERT_NEXT(a_adv_valid, en && s11_s.v, out_valid,
		"valid lost at last stage")

endmodule
